// ===== src/kpsd_pkg.sv =====
// shared constants, types and key legend table for the keypad scanner
`default_nettype none
package kpsd_pkg;

  localparam int unsigned ROWS = 4;
  localparam int unsigned COLS = 4;
  localparam int unsigned KEY_COUNT = ROWS * COLS;
  localparam int unsigned POS_W = $clog2(KEY_COUNT + 1);
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned SCAN_W = ROWS * COLS;
  localparam int unsigned IN_W = 2 * SCAN_W;
  localparam int unsigned OUT_W = KEY_COUNT + 1 + CHAR_W;

  typedef logic [KEY_COUNT-1:0] key_mask_t;
  typedef logic [CHAR_W-1:0] key_char_t;

  // packed from the top bit down, so new_keys lands in the lowest bits
  typedef struct packed {
    key_char_t key_char;
    logic      key_found;
    key_mask_t new_keys;
  } result_t;

  // legend by highest key position plus one, entry zero for no key
  localparam key_char_t KEY_LEGEND [0:KEY_COUNT] = '{
    7'h00,
    7'h31, 7'h32, 7'h33, 7'h41,
    7'h34, 7'h35, 7'h36, 7'h42,
    7'h37, 7'h38, 7'h39, 7'h43,
    7'h2A, 7'h30, 7'h23, 7'h44
  };

endpackage
`default_nettype wire

// ===== src/kpsd_scan.sv =====
// one keypad scan to key mask, lowest pressed row wins
`default_nettype none
module kpsd_scan (
  input  wire logic [kpsd_pkg::SCAN_W-1:0] rows_i,
  output logic      [kpsd_pkg::KEY_COUNT-1:0] mask_o
);
  import kpsd_pkg::*;

  logic [COLS-1:0] cols;

  always_comb begin
    mask_o = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      cols = ~rows_i[r*COLS +: COLS];
      if (cols != '0) begin
        mask_o = '0;
        mask_o[r*COLS +: COLS] = cols;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/kpsd_enc.sv =====
// new key mask to result: found flag and legend of the highest key
`default_nettype none
module kpsd_enc (
  input  wire logic [kpsd_pkg::KEY_COUNT-1:0] fresh_i,
  output kpsd_pkg::result_t                   result_o
);
  import kpsd_pkg::*;

  logic [POS_W-1:0] pos;

  always_comb begin
    pos = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (fresh_i[i]) begin
        pos = POS_W'(i + 1);
      end
    end
  end

  assign result_o.new_keys  = fresh_i;
  assign result_o.key_found = |fresh_i;
  assign result_o.key_char  = KEY_LEGEND[pos];

endmodule
`default_nettype wire

// ===== src/keypad_scan_debounce_edge.sv =====
// top level: keypad scan debounce and new key detection
// Each transaction carries two scans of a 4x4 keypad taken a debounce interval
// apart and yields exactly one result transaction. The block is a two-register
// pipeline: an input register, then scan decode, debounce AND, compare against
// the held key mask and legend encode, all combinational, into an output register.
// It takes one transaction per cycle while the output is not stalled. Each item
// passes from the input register to the output register, which raises output
// valid. The held key mask register updates as each item moves into the
// output register, so items follow back to back.
`default_nettype none
module keypad_scan_debounce_edge (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // first_row0..3_cols, then second_row0..3_cols, 4 bits each from bit 0 up
  input  wire logic [kpsd_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  // new_keys [15:0], key_found [16], key_char [23:17]
  output logic      [kpsd_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import kpsd_pkg::*;

  logic [IN_W-1:0] in_data_q;
  logic            in_valid_q, in_valid_d;
  key_mask_t       held_q, held_d;
  result_t         out_q, result;
  logic            out_valid_q, out_valid_d;
  logic            advance;
  key_mask_t       first_mask, second_mask, stable, fresh;

  kpsd_scan u_scan_first (
    .rows_i (in_data_q[SCAN_W-1:0]),
    .mask_o (first_mask)
  );

  kpsd_scan u_scan_second (
    .rows_i (in_data_q[IN_W-1:SCAN_W]),
    .mask_o (second_mask)
  );

  assign stable = first_mask & second_mask;
  assign fresh  = stable & ~held_q;

  kpsd_enc u_enc (
    .fresh_i  (fresh),
    .result_o (result)
  );

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    held_d = advance ? stable : held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      held_q      <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule
`default_nettype wire

// ===== src/kpsd_checker.sv =====
// port-level checker for the keypad scanner and its bind
`default_nettype none
module kpsd_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid_i,
  input wire logic                       s_axis_tready_o,
  input wire logic                       m_axis_tvalid_o,
  input wire logic                       m_axis_tready_i,
  input wire logic [kpsd_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import kpsd_pkg::*;

  result_t res;
  assign res = m_axis_tdata_o;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // found flag agrees with the mask
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> res.key_found == (res.new_keys != '0))
    else $error("key_found does not match new_keys");

  // a legend exactly when a key is found
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> res.key_found == (res.key_char != '0))
    else $error("key_char does not match key_found");

  // new keys come from one row only
  a_one_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0({|res.new_keys[15:12], |res.new_keys[11:8],
                                  |res.new_keys[7:4], |res.new_keys[3:0]}))
    else $error("new keys span several rows");

  // an accepted transaction is followed by a valid result on the output
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> ##2 m_axis_tvalid_o)
    else $error("no result after accepted transaction");

endmodule

bind keypad_scan_debounce_edge kpsd_checker u_kpsd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
